@@ design/bcnf_pkg.sv @@
// package for the branch coverage novelty filter: sizes, hash primes, fsm states
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package bcnf_pkg;
    localparam int unsigned BITMAP_ENTRIES_DEF = 65536;
    localparam logic [31:0] HP1 = 32'h9E3779B1;
    localparam logic [31:0] HP2 = 32'h85EBCA77;
    localparam logic [31:0] HP3 = 32'hC2B2AE3D;
    localparam logic [31:0] HP4 = 32'h27D4EB2F;
    localparam logic [31:0] HP5 = 32'h165667B1;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_HASH, ST_READ, ST_WAIT, ST_UPD,
        ST_INV_READ, ST_INV_WAIT, ST_INV_UPD, ST_OUT
    } bcnf_state_t;

    function automatic logic [31:0] rotl17(input logic [31:0] x);
        rotl17 = {x[14:0], x[31:15]};
    endfunction

    function automatic logic [31:0] rotl11(input logic [31:0] x);
        rotl11 = {x[20:0], x[31:21]};
    endfunction
endpackage
`default_nettype wire

@@ design/bcnf_hash.sv @@
// iterative 32-bit hash of one branch event, one multiply per cycle
// depends on bcnf_pkg
`timescale 1ns / 1ps
`default_nettype none
module bcnf_hash (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [63:0] addr,
    input  wire logic        taken,
    output logic             done,
    output logic [31:0]      digest
);
    import bcnf_pkg::*;

    logic [3:0]  step_reg, step_next;
    logic        busy_reg, busy_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] mul_a, mul_b, prod;

    always_comb begin
        mul_a = acc_reg;
        mul_b = HP4;
        acc_next = acc_reg;
        case (step_reg)
            4'd0: begin mul_a = addr[31:0];  mul_b = HP3; end
            4'd1: begin mul_a = rotl17(acc_reg); mul_b = HP4; end
            4'd2: begin mul_a = addr[63:32]; mul_b = HP3; end
            4'd3: begin mul_a = rotl17(acc_reg); mul_b = HP4; end
            4'd4: begin mul_a = {31'd0, taken}; mul_b = HP5; end
            4'd5: begin mul_a = rotl11(acc_reg); mul_b = HP1; end
            4'd6: begin mul_a = acc_reg ^ (acc_reg >> 15); mul_b = HP2; end
            4'd7: begin mul_a = acc_reg ^ (acc_reg >> 13); mul_b = HP3; end
            default: begin mul_a = acc_reg; mul_b = HP3; end
        endcase
        prod = mul_a * mul_b;
        case (step_reg)
            4'd0, 4'd2, 4'd4: acc_next = acc_reg + prod;
            4'd8:             acc_next = acc_reg ^ (acc_reg >> 16);
            default:          acc_next = prod;
        endcase
        if (start) acc_next = HP5 + 32'd9;
    end

    always_comb begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = 4'd0;
        end else if (busy_reg) begin
            step_next = step_reg + 4'd1;
            if (step_reg == 4'd8) busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= 4'd0;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
        acc_reg <= acc_next;
    end

    assign done   = busy_reg && (step_reg == 4'd8);
    assign digest = acc_next;
endmodule
`default_nettype wire

@@ design/bcnf_mem.sv @@
// one 8-bit synchronous memory with registered read
// depends on bcnf_pkg for the default depth
`timescale 1ns / 1ps
`default_nettype none
module bcnf_mem #(
    parameter int unsigned ENTRIES = bcnf_pkg::BITMAP_ENTRIES_DEF,
    localparam int unsigned AW = $clog2(ENTRIES)
) (
    input  wire logic          aclk,
    input  wire logic [AW-1:0] raddr,
    output logic [7:0]         rdata,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [7:0]    wdata
);
    import bcnf_pkg::*;
    logic [7:0] mem [ENTRIES];

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ design/branch_coverage_novelty_filter.sv @@
// branch coverage novelty filter top level: hash unit, two bitmap memories, sequencer
// depends on bcnf_pkg, bcnf_hash, bcnf_mem
// sequence: after the accepting edge, one hash run, read, wait, update and output precede m_valid;
//   when interesting, a second hash run and an inverse read, wait and update come before output
// a new event is taken only in idle, after the previous one has passed the output state,
//   and the output state waits while the previous transaction is still unaccepted
// reset: synchronous active low; afterwards a clearing pass over all BITMAP_ENTRIES entries
//   zeroes both memories while s_ready stays low
`timescale 1ns / 1ps
`default_nettype none
module branch_coverage_novelty_filter #(
    parameter int unsigned BITMAP_ENTRIES = bcnf_pkg::BITMAP_ENTRIES_DEF,
    localparam int unsigned AW = $clog2(BITMAP_ENTRIES)
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [63:0] s_branch_address,
    input  wire logic        s_branch_taken,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_interesting
);
    import bcnf_pkg::*;

    bcnf_state_t state_reg, state_next;
    logic [AW:0]   clr_reg, clr_next;      // clearing pass counter
    logic [63:0]   addr_reg;
    logic          taken_reg;
    logic [AW-1:0] prev_reg, prev_next;    // previous hash
    logic [AW-1:0] h_reg, h_next;          // this event's hash
    logic [AW-1:0] idx_reg, idx_next;
    logic [AW-1:0] inv_reg, inv_next;
    logic [7:0]    cnt_reg, cnt_next;      // incremented counter at idx
    logic          hit_reg, hit_next;
    logic          out_valid_reg, out_valid_next;
    logic          inv_pass_reg, inv_pass_next; // hash run is the inverse one

    // hash unit
    logic        h_start, h_done;
    logic [31:0] digest;
    logic        h_taken;

    assign h_taken = inv_pass_reg ? ~taken_reg : taken_reg;

    bcnf_hash u_hash (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (h_start),
        .addr    (addr_reg),
        .taken   (h_taken),
        .done    (h_done),
        .digest  (digest)
    );

    // memories
    logic [AW-1:0] raddr, waddr;
    logic [7:0]    cnt_rd, cov_rd, cnt_wd, cov_wd;
    logic          cnt_we, cov_we;

    bcnf_mem #(.ENTRIES(BITMAP_ENTRIES)) u_cnt (
        .aclk(aclk), .raddr(raddr), .rdata(cnt_rd),
        .we(cnt_we), .waddr(waddr), .wdata(cnt_wd)
    );
    bcnf_mem #(.ENTRIES(BITMAP_ENTRIES)) u_cov (
        .aclk(aclk), .raddr(raddr), .rdata(cov_rd),
        .we(cov_we), .waddr(waddr), .wdata(cov_wd)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:    if (clr_reg == (AW+1)'(BITMAP_ENTRIES - 1)) state_next = ST_IDLE;
            ST_IDLE:     if (s_valid) state_next = ST_HASH;
            ST_HASH:     if (h_done) state_next = inv_pass_reg ? ST_INV_READ : ST_READ;
            ST_READ:     state_next = ST_WAIT;
            ST_WAIT:     state_next = ST_UPD;
            ST_UPD:      state_next = hit_next ? ST_HASH : ST_OUT;
            ST_INV_READ: state_next = ST_INV_WAIT;
            ST_INV_WAIT: state_next = ST_INV_UPD;
            ST_INV_UPD:  state_next = ST_OUT;
            ST_OUT:      if (!out_valid_reg || m_ready) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        clr_next       = clr_reg;
        prev_next      = prev_reg;
        h_next         = h_reg;
        idx_next       = idx_reg;
        inv_next       = inv_reg;
        cnt_next       = cnt_reg;
        hit_next       = hit_reg;
        inv_pass_next  = inv_pass_reg;
        out_valid_next = out_valid_reg;
        h_start = 1'b0;
        raddr   = idx_reg;
        waddr   = idx_reg;
        cnt_we  = 1'b0;
        cov_we  = 1'b0;
        cnt_wd  = cnt_reg;
        cov_wd  = cov_rd | cnt_reg;
        if (out_valid_reg && m_ready) out_valid_next = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                waddr  = clr_reg[AW-1:0];
                cnt_we = 1'b1;
                cov_we = 1'b1;
                cnt_wd = 8'd0;
                cov_wd = 8'd0;
                clr_next = clr_reg + 1'b1;
            end
            ST_IDLE: begin
                if (s_valid) begin
                    h_start = 1'b1;
                    inv_pass_next = 1'b0;
                end
            end
            ST_HASH: begin
                if (h_done) begin
                    if (inv_pass_reg) begin
                        inv_next = (prev_reg >> 1) ^ digest[AW-1:0];
                    end else begin
                        h_next   = digest[AW-1:0];
                        idx_next = (prev_reg >> 1) ^ digest[AW-1:0];
                    end
                end
            end
            ST_READ: raddr = idx_reg;
            ST_WAIT: raddr = idx_reg;
            ST_UPD: begin
                cnt_next = cnt_rd + 8'd1;
                hit_next = ((cnt_next | cov_rd) != cov_rd);
                cnt_wd   = cnt_next;
                cov_wd   = cov_rd | cnt_next;
                cnt_we   = 1'b1;
                cov_we   = hit_next;
                if (hit_next) begin
                    h_start = 1'b1;
                    inv_pass_next = 1'b1;
                end
            end
            // read of inv issued in INV_READ; data returns in INV_WAIT
            ST_INV_READ: raddr = inv_reg;
            ST_INV_WAIT: raddr = inv_reg;
            ST_INV_UPD: begin
                waddr  = inv_reg;
                cov_wd = cov_rd | (cnt_rd + 8'd1);
                cov_we = 1'b1;
            end
            ST_OUT: begin
                if (!out_valid_reg || m_ready) begin
                    out_valid_next = 1'b1;
                    prev_next = h_reg;
                end
            end
            default: ;
        endcase
    end

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = out_valid_reg;
    logic out_bit_reg;
    assign m_interesting = out_bit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            prev_reg      <= '0;
            out_valid_reg <= 1'b0;
            inv_pass_reg  <= 1'b0;
            hit_reg       <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            prev_reg      <= prev_next;
            out_valid_reg <= out_valid_next;
            inv_pass_reg  <= inv_pass_next;
            hit_reg       <= hit_next;
        end
        if (s_valid && s_ready) begin
            addr_reg  <= s_branch_address;
            taken_reg <= s_branch_taken;
        end
        if (state_reg == ST_OUT && (!out_valid_reg || m_ready)) out_bit_reg <= hit_reg;
        h_reg   <= h_next;
        idx_reg <= idx_next;
        inv_reg <= inv_next;
        cnt_reg <= cnt_next;
    end

    // s_ready is high only in idle, never during clear; the hash finishes only in the hash state
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (state_reg == ST_IDLE)) else $error("ready outside idle");
    a_no_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !s_ready) else $error("ready during clear");
    a_hash_done: assert property (@(posedge aclk) disable iff (!aresetn)
        h_done |-> (state_reg == ST_HASH)) else $error("hash done outside hash state");
endmodule
`default_nettype wire
